/* hdl/isqrt_pkg.sv */
package isqrt_pkg;

    // fixed widths of the word fields
    localparam int VALUE_W = 64;
    localparam int ROOT_W  = 32;

    // default operand width used by the top level
    localparam int DATA_WIDTH_DEF = 64;

    // control bits that travel with each word down the pipe
    typedef struct packed {
        logic vld;
        logic neg;
    } t_ctl;

endpackage

/* hdl/isqrt_stage.sv */
module isqrt_stage
    import isqrt_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int N_ITER     = 32,
    parameter int STAGE      = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_ctl                  i_ctl,
    input  logic [DATA_WIDTH-1:0] i_rem,
    input  logic [DATA_WIDTH-1:0] i_part,
    input  logic [N_ITER-1:0]     i_root,
    output t_ctl                  o_ctl,
    output logic [DATA_WIDTH-1:0] o_rem,
    output logic [DATA_WIDTH-1:0] o_part,
    output logic [N_ITER-1:0]     o_root
);

    // trial value for this stage, a power of four
    localparam int SHIFT = 2 * (N_ITER - 1 - STAGE);
    localparam logic [DATA_WIDTH-1:0] TRIAL = DATA_WIDTH'(1) << SHIFT;

    t_ctl                  r_ctl;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_part;
    logic [N_ITER-1:0]     r_root;

    logic [DATA_WIDTH:0]   sum;
    logic                  fit;
    logic [DATA_WIDTH-1:0] part_sh;
    logic [DATA_WIDTH-1:0] n_rem;
    logic [DATA_WIDTH-1:0] n_part;
    logic [N_ITER-1:0]     n_root;

    // one restoring step: compare, subtract, shift a root bit in
    always_comb begin
        sum     = {1'b0, TRIAL} + {1'b0, i_part};
        fit     = ({1'b0, i_rem} >= sum);
        part_sh = i_part >> 1;
        n_rem   = fit ? (i_rem - sum[DATA_WIDTH-1:0]) : i_rem;
        n_part  = fit ? (part_sh | TRIAL) : part_sh;
        n_root  = {i_root[N_ITER-2:0], fit};
    end

    // control bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_part <= n_part;
            r_root <= n_root;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_part = r_part;
    assign o_root = r_root;

endmodule

/* hdl/integer_square_root_unit.sv */
// Integer square root of a signed operand, floor(sqrt(value)), by the restoring
// binary digit-by-digit method. Only the low DATA_WIDTH bits of i_value are used,
// with bit DATA_WIDTH-1 as the sign; a negative operand gives root zero and
// o_negative_error set. Each pipeline stage resolves one root bit, so the block
// has N_ITER = (DATA_WIDTH-2)/2 + 1 stages (32 at the default width of 64): a word
// passes through N_ITER registered stages, and a new word can enter every cycle while o_ready is high.
// The whole pipe advances together; it holds only while the output word waits
// and the downstream side is not ready, and no reset-time sweep is needed.
module integer_square_root_unit
    import isqrt_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [ROOT_W-1:0]  o_root,
    output logic               o_negative_error
);

    localparam int N_ITER = (DATA_WIDTH - 2) / 2 + 1;

    t_ctl                  ctl  [N_ITER+1];
    logic [DATA_WIDTH-1:0] rem  [N_ITER+1];
    logic [DATA_WIDTH-1:0] part [N_ITER+1];
    logic [N_ITER-1:0]     root [N_ITER+1];
    logic                  en;
    logic                  neg;

    // pipe advances unless the output word is stuck
    assign en      = !ctl[N_ITER].vld || i_ready;
    assign o_ready = en;

    // stage input: a negative operand starts with zero remainder, giving root zero
    assign neg         = i_value[DATA_WIDTH-1];
    assign ctl[0].vld  = i_valid;
    assign ctl[0].neg  = neg;
    assign rem[0]      = neg ? '0 : i_value[DATA_WIDTH-1:0];
    assign part[0]     = '0;
    assign root[0]     = '0;

    // one stage per root bit
    for (genvar k = 0; k < N_ITER; k++) begin : g_stage
        isqrt_stage #(
            .DATA_WIDTH (DATA_WIDTH),
            .N_ITER     (N_ITER),
            .STAGE      (k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (ctl[k]),
            .i_rem   (rem[k]),
            .i_part  (part[k]),
            .i_root  (root[k]),
            .o_ctl   (ctl[k+1]),
            .o_rem   (rem[k+1]),
            .o_part  (part[k+1]),
            .o_root  (root[k+1])
        );
    end

    // output word
    assign o_valid          = ctl[N_ITER].vld;
    assign o_negative_error = ctl[N_ITER].neg;
    assign o_root           = ROOT_W'(root[N_ITER]);

`ifndef SYNTHESIS
    // a negative operand must come out with a zero root
    a_neg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_negative_error |-> o_root == '0)
        else $error("negative operand produced a nonzero root");

    // the pipe only stalls when a finished word is waiting
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("pipe stalled with no word at the output");

    // root never needs more bits than the number of resolved bits
    a_root_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_root >> N_ITER) == '0)
        else $error("root wider than the stage count");
`endif

endmodule
